>>> sv/lba_pkg.sv
// shared widths, codes and control bundles of the linked block allocator
package lba_pkg;

	// fixed field widths
	localparam int OP_W     = 1;
	localparam int LEN_W    = 12;
	localparam int START_W  = 10;
	localparam int STATUS_W = 2;
	localparam int FIRST_W  = 10;
	localparam int COUNT_W  = 11;
	localparam int MARK_W   = 2;

	// default geometry
	localparam int DEF_BLOCK_COUNT     = 1024;
	localparam int DEF_RESERVED_BLOCKS = 32;
	localparam int DEF_BLOCK_UNITS     = 2;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [MARK_W-1:0]   mark_t;

	localparam op_t OP_ALLOC = 1'b0;
	localparam op_t OP_FREE  = 1'b1;

	localparam status_t ST_DONE    = 2'd0;
	localparam status_t ST_NOSPACE = 2'd1;
	localparam status_t ST_INVALID = 2'd2;

	localparam mark_t MARK_FREE = 2'd0;
	localparam mark_t MARK_USED = 2'd1;
	localparam mark_t MARK_RESV = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    step;
		logic    emit;
		status_t res_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op_free;
		logic zero_len;
		logic no_space;
		logic cur_ok;
		logic last;
	} sts_t;

endpackage

>>> sv/linked_block_allocator_core.sv
// top level of the linked free list disk block allocator
//
// one request channel (in_valid / in_stall) carries op, length and start_block;
// one result channel (out_valid / out_stall) carries status, first_block and
// block_count, exactly one result transfer per request transfer, in order.
// an allocate or a free stays in work while its chain is walked and until its
// result is handed off, a refused request only until its result is handed off;
// with 1024 blocks of which 32 are reserved a chain holds at most 992 blocks.
// the walk follows one link per cycle through the single read port of the
// block table.
// requests are taken one at a time; in_stall is high while one is in work.
// results land in an output register, so a new request is taken while the
// last result still waits; if the receiver stalls, the next result waits in
// the controller until the register is free, and no request is taken then.
// reset sets up the free list at once: entries never written since reset
// read as their reset contents through a fill mark, so there is no clearing
// pass and the first request may follow reset directly.
module linked_block_allocator_core #(
	parameter int BLOCK_COUNT     = lba_pkg::DEF_BLOCK_COUNT,
	parameter int RESERVED_BLOCKS = lba_pkg::DEF_RESERVED_BLOCKS,
	parameter int BLOCK_UNITS     = lba_pkg::DEF_BLOCK_UNITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lba_pkg::OP_W-1:0]      op,
	input  logic [lba_pkg::LEN_W-1:0]     length,
	input  logic [lba_pkg::START_W-1:0]   start_block,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lba_pkg::STATUS_W-1:0]  status,
	output logic [lba_pkg::FIRST_W-1:0]   first_block,
	output logic [lba_pkg::COUNT_W-1:0]   block_count
);
	import lba_pkg::*;

	// command and status bundles between the sequencer and the tables
	cmd_t cmd;
	sts_t sts;

	// sequencer: checks, walk steps and result hand-off
	lba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// block tables, free list head and count, result register
	lba_dp #(
		.BLOCK_COUNT     (BLOCK_COUNT),
		.RESERVED_BLOCKS (RESERVED_BLOCKS),
		.BLOCK_UNITS     (BLOCK_UNITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.length      (length),
		.start_block (start_block),
		.status      (status),
		.first_block (first_block),
		.block_count (block_count)
	);

endmodule

>>> sv/lba_ctrl.sv
// sequencing state machine of the linked block allocator
module lba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  lba_pkg::sts_t sts,
	output lba_pkg::cmd_t cmd
);
	import lba_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_FIRST  = 4'b0010,
		S_WALK   = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t  state_q, state_d;
	status_t st_q, st_d;
	logic    out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		st_d = st_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_FIRST;
				end
			end
			S_FIRST: begin
				if (!sts.op_free) begin
					if (sts.zero_len) begin
						st_d = ST_INVALID;
						state_d = S_RESULT;
					end else if (sts.no_space) begin
						st_d = ST_NOSPACE;
						state_d = S_RESULT;
					end else begin
						cmd.step = 1'b1;
						st_d = ST_DONE;
						state_d = sts.last ? S_RESULT : S_WALK;
					end
				end else if (!sts.cur_ok) begin
					st_d = ST_INVALID;
					state_d = S_RESULT;
				end else begin
					cmd.step = 1'b1;
					st_d = ST_DONE;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (!sts.op_free) begin
					cmd.step = 1'b1;
					if (sts.last) begin
						state_d = S_RESULT;
					end
				end else if (sts.cur_ok) begin
					cmd.step = 1'b1;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd.res_status = st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= ST_DONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("result loaded over one not yet transferred");

	a_step_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (state_q == S_FIRST || state_q == S_WALK))
		else $error("table step outside a walk");

endmodule

>>> sv/lba_dp.sv
// block tables, free list registers and result register of the allocator
module lba_dp #(
	parameter int BLOCK_COUNT     = lba_pkg::DEF_BLOCK_COUNT,
	parameter int RESERVED_BLOCKS = lba_pkg::DEF_RESERVED_BLOCKS,
	parameter int BLOCK_UNITS     = lba_pkg::DEF_BLOCK_UNITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lba_pkg::cmd_t                 cmd,
	output lba_pkg::sts_t                 sts,
	input  logic [lba_pkg::OP_W-1:0]      op,
	input  logic [lba_pkg::LEN_W-1:0]     length,
	input  logic [lba_pkg::START_W-1:0]   start_block,
	output logic [lba_pkg::STATUS_W-1:0]  status,
	output logic [lba_pkg::FIRST_W-1:0]   first_block,
	output logic [lba_pkg::COUNT_W-1:0]   block_count
);
	import lba_pkg::*;

	localparam int AW = $clog2(BLOCK_COUNT);
	localparam int LW = $clog2(BLOCK_COUNT + 1);
	localparam int EW = LW + MARK_W;
	localparam int SW = (LW > START_W) ? LW : START_W;
	localparam int PW = (LW + 7 > LEN_W) ? LW + 7 : LEN_W;
	localparam int RES_LIM = (RESERVED_BLOCKS < BLOCK_COUNT) ? RESERVED_BLOCKS : BLOCK_COUNT;

	localparam logic [LW-1:0] END_LINK  = LW'(BLOCK_COUNT);
	localparam logic [LW-1:0] WM_RST    = LW'(RES_LIM);
	localparam logic [LW-1:0] HEAD_RST  = (RESERVED_BLOCKS < BLOCK_COUNT) ?
		LW'(RESERVED_BLOCKS) : END_LINK;
	localparam logic [LW-1:0] TOTAL_RST = LW'(BLOCK_COUNT - RES_LIM);

	// entry word: mark above link
	logic [EW-1:0] mem [BLOCK_COUNT];

	op_t            op_q;
	logic [LEN_W-1:0] rem_q;
	logic [LW-1:0]  cnt_q;
	logic [AW-1:0]  cur_q;
	logic           cur_in_q;
	logic [AW-1:0]  first_q;
	logic [LW-1:0]  head_q;
	logic [LW-1:0]  total_q;
	logic [LW-1:0]  wm_q;

	logic [EW-1:0]  rd_raw_q;
	logic [EW-1:0]  rd_byp_data_q;
	logic           rd_byp_q;
	logic           rd_fresh_q;
	logic           rd_resv_q;

	logic [EW-1:0]  rd_entry;
	logic [LW-1:0]  rd_link;
	mark_t          rd_mark;
	logic           link_in;

	logic [SW-1:0]  start_ext;
	logic           ld_in;
	logic [AW-1:0]  ld_addr;

	logic           re;
	logic [AW-1:0]  raddr;
	logic           we;
	logic [EW-1:0]  wdata;
	logic [PW-1:0]  room_units;
	logic           last;
	logic           ok;

	// entries beyond the fill mark still hold their reset contents
	always_comb begin
		if (rd_byp_q) begin
			rd_entry = rd_byp_data_q;
		end else if (rd_resv_q) begin
			rd_entry = {MARK_RESV, END_LINK};
		end else if (rd_fresh_q) begin
			rd_entry = {MARK_FREE, LW'(cur_q) + LW'(1)};
		end else begin
			rd_entry = rd_raw_q;
		end
	end

	assign rd_link = rd_entry[LW-1:0];
	assign rd_mark = rd_entry[EW-1 -: MARK_W];
	assign link_in = (rd_link < END_LINK);

	assign start_ext = SW'(start_block);
	assign ld_in   = (op == OP_FREE) ? (start_ext < SW'(BLOCK_COUNT)) : (head_q < END_LINK);
	assign ld_addr = (op == OP_FREE) ? start_ext[AW-1:0] : head_q[AW-1:0];

	assign last       = (rem_q <= LEN_W'(BLOCK_UNITS));
	assign room_units = PW'(total_q) * PW'(BLOCK_UNITS);

	assign re    = (cmd.load && ld_in) || (cmd.step && link_in);
	assign raddr = cmd.load ? ld_addr : rd_link[AW-1:0];
	assign we    = cmd.step;
	always_comb begin
		if (op_q == OP_FREE) begin
			wdata = {MARK_FREE, head_q};
		end else begin
			wdata = {MARK_USED, last ? END_LINK : rd_link};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[cur_q] <= wdata;
		end
		if (re) begin
			rd_raw_q <= mem[raddr];
			rd_byp_q <= we && (cur_q == raddr);
			rd_byp_data_q <= wdata;
			rd_fresh_q <= (LW'(raddr) >= wm_q);
			rd_resv_q <= (32'(raddr) < RESERVED_BLOCKS);
		end
	end

	// request registers and walk pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			rem_q <= length;
			cnt_q <= '0;
			cur_q <= ld_addr;
			cur_in_q <= ld_in;
			first_q <= head_q[AW-1:0];
		end else if (cmd.step) begin
			rem_q <= rem_q - LEN_W'(BLOCK_UNITS);
			cnt_q <= cnt_q + LW'(1);
			cur_q <= rd_link[AW-1:0];
			cur_in_q <= link_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= HEAD_RST;
			total_q <= TOTAL_RST;
			wm_q <= WM_RST;
		end else if (cmd.step) begin
			if (op_q == OP_FREE) begin
				head_q <= LW'(cur_q);
				total_q <= total_q + LW'(1);
			end else begin
				head_q <= rd_link;
				total_q <= total_q - LW'(1);
			end
			if (LW'(cur_q) == wm_q) begin
				wm_q <= wm_q + LW'(1);
			end
		end
	end

	assign sts.op_free  = (op_q == OP_FREE);
	assign sts.zero_len = (rem_q == '0);
	assign sts.no_space = (PW'(rem_q) > room_units) || !cur_in_q;
	assign sts.cur_ok   = cur_in_q && (rd_mark == MARK_USED);
	assign sts.last     = last;

	// result register
	assign ok = (cmd.res_status == ST_DONE);
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status <= cmd.res_status;
			first_block <= (ok && op_q == OP_ALLOC) ? FIRST_W'(first_q) : '0;
			block_count <= ok ? COUNT_W'(cnt_q) : '0;
		end
	end

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> cur_in_q)
		else $error("table write outside the block range");

	a_fill_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(wm_q >= WM_RST) && (wm_q <= END_LINK))
		else $error("fill mark out of range");

	a_free_total: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOTAL_RST)
		else $error("free total above the free area size");

endmodule
